// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers for the rtl top, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// File: rtl/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg
// shared types and constants of the rgb led bit serializer
// ----------------------------------------------------------------------------
`default_nettype none

package lbs_pkg;

    // matrix geometry
    localparam int WIDTH    = 8;
    localparam int HEIGHT   = 8;
    localparam int NPIX     = WIDTH * HEIGHT;
    localparam int ADDR_W   = (NPIX > 1) ? $clog2(NPIX) : 1;
    localparam int CNT_W    = $clog2(NPIX + 1);

    // pixel word: green high, red middle, blue low
    localparam int PIX_BITS = 24;
    localparam int BIT_W    = 5;
    localparam int TIME_W   = 8;
    localparam int COORD_W  = 3;
    localparam int LIN_W    = 12;

    localparam logic [TIME_W-1:0] RESET_LOW_TIME  = 8'd26;
    localparam logic [TIME_W-1:0] RESET_HIGH_TIME = 8'd50;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_TIME  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_TIME = 1'b1;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_START = 2'd1,
        KIND_TICK  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COPY,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic pix_write;
        logic copy_begin;
        logic copy_step;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic sending;
        logic copy_done;
        logic out_free;
    } dpath_status_t;

endpackage

`default_nettype wire

// File: rtl/rgb_led_bit_serializer.sv
// ----------------------------------------------------------------------------
// rgb_led_bit_serializer
// 8x8 rgb led frame store with serial pwm compare value output
// ----------------------------------------------------------------------------
// usage
//   s_* channel takes one item: tuser holds the kind (pixel write, start,
//   tick), tdata the coordinates and colors. a pixel write stores g/r/b
//   into the edit store. a start copies the edit store into the send
//   store through a sweep (one entry per cycle, bounded by the single
//   read port of the edit ram), s_tready stays low meanwhile; a start
//   while a frame is running is dropped.
//   each tick while sending yields one item on m_*: tdata is the compare
//   value (high_time for a one, low_time for a zero), tlast marks the final
//   bit of the frame. a tick goes through the send ram read, then compare
//   select into the output register; the next tick waits until it has left
//   the emit step. ticks while idle are swallowed with no item out. if the
//   receiver stalls, the result waits in the output register; pixel writes
//   and starts still flow, a following tick waits in the emit step with s_tready low.
//   cfg_* writes low_time (index 0) or high_time (index 1), always ready.
//   reset: low_time 26, high_time 50, idle, edit store reads all zero.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rgb_led_bit_serializer import lbs_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input items
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [31:0]          s_tdata,  // col[2:0] row[5:3] red[13:6] green[21:14] blue[29:22]
    input  wire logic [1:0]           s_tuser,  // kind[1:0]
    // result items
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,  // compare_value[7:0]
    output logic                      m_tlast,  // last bit of the frame
    // configuration writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TIME_W-1:0]    cfg_data
);

    ctrl_cmd_t     cmd;
    dpath_status_t status;

    // registers accept a write in any cycle
    assign cfg_ready = 1'b1;

    lbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lbs_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .col           (s_tdata[2:0]),
        .row           (s_tdata[5:3]),
        .red           (s_tdata[13:6]),
        .green         (s_tdata[21:14]),
        .blue          (s_tdata[29:22]),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .compare_value (m_tdata),
        .last_bit      (m_tlast)
    );

    // a result is only formed while a frame is running
    `ASSERT_CLK(a_emit_sending, clk, rst_n, cmd.emit |-> status.sending, "emit while idle")

    // input is held off for the whole copy sweep
    `ASSERT_CLK(a_copy_stall, clk, rst_n, cmd.copy_step |-> !s_tready, "input taken during copy")

    // a frame only begins at the end of a copy sweep
    `ASSERT_CLK(a_send_after_copy, clk, rst_n,
        $rose(status.sending) |-> $past(cmd.copy_step), "frame began without copy")

    // store writes, copy and emit never overlap
    `ASSERT_NEVER(a_cmd_overlap, clk, rst_n,
        !$onehot0({cmd.pix_write, cmd.copy_step, cmd.emit}), "overlapping commands")

endmodule

`default_nettype wire

// File: rtl/lbs_ram.sv
// ----------------------------------------------------------------------------
// lbs_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lbs_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/lbs_ctrl.sv
// ----------------------------------------------------------------------------
// lbs_ctrl
// sequencer: input handshake, frame copy and bit emission control
// ----------------------------------------------------------------------------
`default_nettype none

module lbs_ctrl import lbs_pkg::*; (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [1:0]    in_kind,
    output logic               in_ready,
    input  wire dpath_status_t status,
    output ctrl_cmd_t          cmd
);

    state_t state_reg;
    state_t state_next;
    kind_t  kind;
    logic   accept;

    assign kind   = kind_t'(in_kind);
    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        KIND_START:
                        begin
                            if (!status.sending)
                            begin
                                state_next = ST_COPY;
                            end
                        end
                        KIND_TICK:
                        begin
                            if (status.sending)
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_COPY:
            begin
                if (status.copy_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready       = 1'b0;
        cmd.pix_write  = 1'b0;
        cmd.copy_begin = 1'b0;
        cmd.copy_step  = 1'b0;
        cmd.emit       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.pix_write  = in_valid && (kind == KIND_PIXEL);
                cmd.copy_begin = in_valid && (kind == KIND_START) && !status.sending;
            end
            ST_COPY:
            begin
                cmd.copy_step = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/lbs_dpath.sv
// ----------------------------------------------------------------------------
// lbs_dpath
// frame stores, copy counter, bit position and result register
// ----------------------------------------------------------------------------
`default_nettype none

module lbs_dpath import lbs_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ctrl_cmd_t            cmd,
    output dpath_status_t             status,
    input  wire logic [COORD_W-1:0]   col,
    input  wire logic [COORD_W-1:0]   row,
    input  wire logic [7:0]           red,
    input  wire logic [7:0]           green,
    input  wire logic [7:0]           blue,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TIME_W-1:0]    cfg_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [TIME_W-1:0]         compare_value,
    output logic                      last_bit
);

    // configuration
    logic [TIME_W-1:0] low_time_reg;
    logic [TIME_W-1:0] high_time_reg;

    // edit store entry valid bits, an unwritten entry reads as zero
    logic              valid_reg [NPIX];
    logic              valid_next [NPIX];
    logic              valid_q_reg;

    // control state
    logic              sending_reg;
    logic              sending_next;
    logic [CNT_W-1:0]  copy_cnt_reg;
    logic [CNT_W-1:0]  copy_cnt_next;
    logic [ADDR_W-1:0] pixel_pos_reg;
    logic [ADDR_W-1:0] pixel_pos_next;
    logic [BIT_W-1:0]  bit_pos_reg;
    logic [BIT_W-1:0]  bit_pos_next;

    // result register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [TIME_W-1:0] compare_reg;
    logic [TIME_W-1:0] compare_next;
    logic              last_reg;
    logic              last_next;

    // store ports
    logic                edit_wr_en;
    logic [ADDR_W-1:0]   edit_wr_addr;
    logic [PIX_BITS-1:0] edit_wr_data;
    logic [ADDR_W-1:0]   edit_rd_addr;
    logic [PIX_BITS-1:0] edit_rd_data;
    logic                send_wr_en;
    logic [ADDR_W-1:0]   send_wr_addr;
    logic [PIX_BITS-1:0] send_wr_data;
    logic [PIX_BITS-1:0] send_rd_data;

    logic [LIN_W-1:0]    lin_addr;
    logic                in_range;
    logic                copy_done;
    logic [BIT_W-1:0]    bit_idx;
    logic                bit_one;
    logic                pix_last;
    logic                bit_last;
    logic                frame_last;

    // pixel write address
    assign lin_addr = LIN_W'(row) * LIN_W'(WIDTH) + LIN_W'(col);
    assign in_range = (32'(col) < 32'(WIDTH)) && (32'(row) < 32'(HEIGHT));

    assign edit_wr_en   = cmd.pix_write && in_range;
    assign edit_wr_addr = lin_addr[ADDR_W-1:0];
    assign edit_wr_data = {green, red, blue};
    assign edit_rd_addr = copy_cnt_reg[ADDR_W-1:0];

    // copy pipeline: read edit entry n while send entry n-1, read in the cycle before, is written
    assign copy_done    = (copy_cnt_reg == CNT_W'(NPIX));
    assign send_wr_en   = cmd.copy_step && (copy_cnt_reg != '0);
    assign send_wr_addr = ADDR_W'(copy_cnt_reg - CNT_W'(1));
    assign send_wr_data = valid_q_reg ? edit_rd_data : '0;

    lbs_ram #(
        .DATA_W (PIX_BITS),
        .DEPTH  (NPIX)
    ) u_edit_ram (
        .clk     (clk),
        .wr_en   (edit_wr_en),
        .wr_addr (edit_wr_addr),
        .wr_data (edit_wr_data),
        .rd_addr (edit_rd_addr),
        .rd_data (edit_rd_data)
    );

    lbs_ram #(
        .DATA_W (PIX_BITS),
        .DEPTH  (NPIX)
    ) u_send_ram (
        .clk     (clk),
        .wr_en   (send_wr_en),
        .wr_addr (send_wr_addr),
        .wr_data (send_wr_data),
        .rd_addr (pixel_pos_reg),
        .rd_data (send_rd_data)
    );

    // bit selection, msb first
    assign bit_idx    = BIT_W'(PIX_BITS - 1) - bit_pos_reg;
    assign bit_one    = send_rd_data[bit_idx];
    assign pix_last   = (pixel_pos_reg == ADDR_W'(NPIX - 1));
    assign bit_last   = (bit_pos_reg == BIT_W'(PIX_BITS - 1));
    assign frame_last = pix_last && bit_last;

    always_comb
    begin
        valid_next = valid_reg;
        if (edit_wr_en)
        begin
            valid_next[edit_wr_addr] = 1'b1;
        end
    end

    always_comb
    begin
        sending_next   = sending_reg;
        copy_cnt_next  = copy_cnt_reg;
        pixel_pos_next = pixel_pos_reg;
        bit_pos_next   = bit_pos_reg;
        if (cmd.copy_begin)
        begin
            copy_cnt_next = '0;
        end
        else if (cmd.copy_step)
        begin
            copy_cnt_next = copy_cnt_reg + CNT_W'(1);
            if (copy_done)
            begin
                sending_next   = 1'b1;
                pixel_pos_next = '0;
                bit_pos_next   = '0;
            end
        end
        else if (cmd.emit)
        begin
            if (frame_last)
            begin
                sending_next   = 1'b0;
                pixel_pos_next = '0;
                bit_pos_next   = '0;
            end
            else if (bit_last)
            begin
                pixel_pos_next = pixel_pos_reg + ADDR_W'(1);
                bit_pos_next   = '0;
            end
            else
            begin
                bit_pos_next = bit_pos_reg + BIT_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        compare_next   = compare_reg;
        last_next      = last_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            compare_next   = bit_one ? high_time_reg : low_time_reg;
            last_next      = frame_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_time_reg  <= RESET_LOW_TIME;
            high_time_reg <= RESET_HIGH_TIME;
            for (int i = 0; i < NPIX; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            sending_reg   <= 1'b0;
            copy_cnt_reg  <= '0;
            pixel_pos_reg <= '0;
            bit_pos_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == REG_LOW_TIME))
            begin
                low_time_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == REG_HIGH_TIME))
            begin
                high_time_reg <= cfg_data;
            end
            valid_reg     <= valid_next;
            sending_reg   <= sending_next;
            copy_cnt_reg  <= copy_cnt_next;
            pixel_pos_reg <= pixel_pos_next;
            bit_pos_reg   <= bit_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        valid_q_reg <= valid_reg[edit_rd_addr];
        compare_reg <= compare_next;
        last_reg    <= last_next;
    end

    assign status.sending   = sending_reg;
    assign status.copy_done = copy_done;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign compare_value = compare_reg;
    assign last_bit      = last_reg;

endmodule

`default_nettype wire
